// ===== rtl/sett_pkg.sv =====
// Package for the sorted expiry timer table: item types, codes and sizes.
// Used by every module of the block; depends on nothing.
`default_nettype none
package sett_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int RESULT_LIMIT = 32;
  localparam int NW = $clog2(RESULT_LIMIT + 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_ADJUST = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_TICK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DUPLICATE = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  timer_id;
    logic [31:0] expire_time;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic       expired_valid;
    logic [7:0] expired_id;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Decoded command as it waits between the front and the engine.
  typedef struct packed {
    action_t     op;
    logic [7:0]  id;
    logic [31:0] tval;
  } cmd_t;

  typedef struct packed {
    logic [31:0] expiry;
    logic [7:0]  handle;
  } entry_t;

endpackage
`default_nettype wire

// ===== rtl/sett_cmd_front.sv =====
// Front of the timer table: accepts items, decodes them into commands and
// holds them in a two-entry queue for the engine. Depends on sett_pkg.
`default_nettype none
module sett_cmd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire sett_pkg::in_item_t cmd,
  output logic                   cmd_valid,
  output sett_pkg::cmd_t         cmd_head,
  input  wire logic              cmd_take
);

  sett_pkg::cmd_t q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  sett_pkg::cmd_t dec;
  logic           do_push;
  logic           do_pop;

  // Add and adjust carry the expiry, a tick carries the current time.
  always_comb begin
    dec.op = sett_pkg::action_t'(cmd.action);
    dec.id = cmd.timer_id;
    unique case (sett_pkg::action_t'(cmd.action))
      sett_pkg::ACT_ADD, sett_pkg::ACT_ADJUST: dec.tval = cmd.expire_time;
      sett_pkg::ACT_DELETE:                     dec.tval = '0;
      default:                                  dec.tval = cmd.now_time;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd_head  = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sett_out_queue.sv =====
// Two-entry result queue that parts the engine from the result port.
// Depends on sett_pkg.
`default_nettype none
module sett_out_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_push,
  input  wire sett_pkg::out_item_t in_data,
  output logic                     in_ready,
  output logic                     empty,
  input  wire logic                pop,
  output sett_pkg::out_item_t      result
);

  sett_pkg::out_item_t q [2];
  logic                wp;
  logic                rp;
  logic [1:0]          cnt;
  logic                do_push;
  logic                do_pop;

  assign in_ready = (cnt != 2'd2);
  assign empty    = (cnt == 2'd0);
  assign result   = q[rp];
  assign do_push  = in_push && in_ready;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sett_engine.sv =====
// Back of the timer table: two table banks, each pass streams the sorted
// entries from one bank into the other. Depends on sett_pkg.
`default_nettype none
module sett_engine #(
  parameter int TABLE_DEPTH = sett_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire sett_pkg::cmd_t  cmd_head,
  output logic                 cmd_take,
  output logic                 out_push,
  output sett_pkg::out_item_t  out_data,
  input  wire logic            out_ready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int WW = $clog2(TABLE_DEPTH + 2);
  localparam int NW = sett_pkg::NW;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  sett_pkg::entry_t mem_a [TABLE_DEPTH];
  sett_pkg::entry_t mem_b [TABLE_DEPTH];
  sett_pkg::entry_t rd_a, rd_b, cur_e, wr_data;

  state_t         state, state_next;
  sett_pkg::cmd_t op, op_next;
  logic           bank, bank_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  r, r_next;
  logic [WW-1:0]  w, w_next;
  logic [NW-1:0]  n, n_next;
  logic           found, found_next;
  logic           ins, ins_next;
  logic           pend, pend_next;
  logic [7:0]     pend_id, pend_id_next;
  logic           wr_en;
  logic           in_left;
  logic           ins_pend;
  logic [AW-1:0]  rd_addr;
  sett_pkg::status_t st;

  assign cur_e   = bank ? rd_b : rd_a;
  assign in_left = (r < count);
  assign rd_addr = (r_next < CW'(TABLE_DEPTH)) ? r_next[AW-1:0] : '0;

  always_comb begin
    state_next   = state;
    op_next      = op;
    bank_next    = bank;
    count_next   = count;
    r_next       = r;
    w_next       = w;
    n_next       = n;
    found_next   = found;
    ins_next     = ins;
    pend_next    = pend;
    pend_id_next = pend_id;
    wr_en        = 1'b0;
    wr_data      = cur_e;
    cmd_take     = 1'b0;
    out_push     = 1'b0;
    out_data     = '0;
    st           = sett_pkg::ST_OK;
    ins_pend     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take     = 1'b1;
          op_next      = cmd_head;
          r_next       = '0;
          w_next       = '0;
          n_next       = '0;
          found_next   = 1'b0;
          ins_next     = 1'b0;
          pend_next    = 1'b0;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        if (op.op == sett_pkg::ACT_TICK) begin
          if (in_left) begin
            if (n < NW'(sett_pkg::RESULT_LIMIT) && cur_e.expiry <= op.tval) begin
              // Due entry: the previous pop goes out once this one is known.
              if (!pend || out_ready) begin
                out_push     = pend;
                out_data     = {1'b1, pend_id, sett_pkg::ST_OK, 1'b0};
                pend_next    = 1'b1;
                pend_id_next = cur_e.handle;
                n_next       = n + 1'b1;
                r_next       = r + 1'b1;
              end
            end else begin
              wr_en  = 1'b1;
              w_next = w + 1'b1;
              r_next = r + 1'b1;
            end
          end else if (out_ready) begin
            out_push   = 1'b1;
            out_data   = pend ? {1'b1, pend_id, sett_pkg::ST_OK, 1'b1}
                              : {1'b0, 8'd0, sett_pkg::ST_OK, 1'b1};
            bank_next  = ~bank;
            count_next = w[CW-1:0];
            state_next = S_IDLE;
          end
        end else begin
          ins_pend = !ins && (op.op == sett_pkg::ACT_ADJUST ||
                     (op.op == sett_pkg::ACT_ADD && count != CW'(TABLE_DEPTH)));
          if (in_left) begin
            if (ins_pend && cur_e.expiry > op.tval) begin
              wr_en    = 1'b1;
              wr_data  = {op.tval, op.id};
              w_next   = w + 1'b1;
              ins_next = 1'b1;
            end else if (cur_e.handle == op.id) begin
              found_next = 1'b1;
              r_next     = r + 1'b1;
            end else begin
              wr_en  = 1'b1;
              w_next = w + 1'b1;
              r_next = r + 1'b1;
            end
          end else if (ins_pend) begin
            wr_en    = 1'b1;
            wr_data  = {op.tval, op.id};
            w_next   = w + 1'b1;
            ins_next = 1'b1;
          end else if (out_ready) begin
            if (op.op == sett_pkg::ACT_ADD) begin
              if (found) st = sett_pkg::ST_DUPLICATE;
              else if (count == CW'(TABLE_DEPTH)) st = sett_pkg::ST_FULL;
            end else if (!found) begin
              st = sett_pkg::ST_NOT_FOUND;
            end
            out_push = 1'b1;
            out_data = {1'b0, 8'd0, st, 1'b1};
            if (st == sett_pkg::ST_OK) begin
              bank_next  = ~bank;
              count_next = w[CW-1:0];
            end
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a <= mem_a[rd_addr];
    rd_b <= mem_b[rd_addr];
    if (wr_en && w < WW'(TABLE_DEPTH)) begin
      if (bank) mem_a[w[AW-1:0]] <= wr_data;
      else      mem_b[w[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    r       <= r_next;
    w       <= w_next;
    n       <= n_next;
    found   <= found_next;
    ins     <= ins_next;
    pend_id <= pend_id_next;
    if (rst) begin
      state <= S_IDLE;
      bank  <= 1'b0;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      bank  <= bank_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_read_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> r <= count)
    else $error("read index beyond entry count");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    out_push |-> out_ready)
    else $error("result pushed into a full queue");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !out_push && !wr_en)
    else $error("engine active while idle");

endmodule
`default_nettype wire

// ===== rtl/sorted_expiry_timer_table.sv =====
// Sorted expiry timer table. Each item takes one pass over the stored entries,
// which lengthens while the result side stalls. Throughput is one item per
// pass, set by the single read port of the bank. The result of an add, adjust
// or delete shows on the result ports once its pass ends; a tick shows each
// popped timer once the next due entry has been seen, the last one when the
// pass ends.
// Reset (rst, synchronous) empties the table at once; no clearing pass.
`default_nettype none
module sorted_expiry_timer_table #(
  parameter int TABLE_DEPTH = sett_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire sett_pkg::in_item_t  cmd,
  output logic                     empty,
  input  wire logic                pop,
  output sett_pkg::out_item_t      result
);

  // The front decodes each item into a command and queues it, so the port
  // keeps taking items while the engine walks the table.
  sett_pkg::cmd_t      cmd_head;
  logic                cmd_valid;
  logic                cmd_take;
  sett_pkg::out_item_t eng_data;
  logic                eng_push;
  logic                eng_ready;

  sett_cmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_take  (cmd_take)
  );

  // The engine streams the sorted table from one bank into the other,
  // dropping, inserting or popping entries on the way. The new bank is
  // taken only when the command succeeds, so failed commands leave the
  // table as it was. Popped timers are reported in expiry order.
  sett_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_take  (cmd_take),
    .out_push  (eng_push),
    .out_data  (eng_data),
    .out_ready (eng_ready)
  );

  // Results wait here so the engine holds only once this queue is full while the sink stalls.
  sett_out_queue u_out (
    .clk      (clk),
    .rst      (rst),
    .in_push  (eng_push),
    .in_data  (eng_data),
    .in_ready (eng_ready),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
`default_nettype wire
